FILE: src/lrgd_pkg.sv
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared types, codes and saturation helpers for the gradient descent trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrgd_pkg;

  localparam int FEATURES = 8;
  localparam int ROWS     = 256;
  localparam int FW       = $clog2(FEATURES);
  localparam int RW       = $clog2(ROWS);
  localparam int WW       = 68;

  localparam logic signed [WW-1:0] MAX48 = 68'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [WW-1:0] MIN48 = -MAX48 - 68'sd1;
  localparam logic signed [WW-1:0] MAX32 = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [WW-1:0] MIN32 = -MAX32 - 68'sd1;

  localparam logic [1:0] FUNC_FEAT   = 2'd0;
  localparam logic [1:0] FUNC_TARGET = 2'd1;
  localparam logic [1:0] FUNC_PARAM  = 2'd2;
  localparam logic [1:0] FUNC_TRAIN  = 2'd3;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_LOSS   = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_L1   = 2'd1;
  localparam logic [1:0] MODE_L2   = 2'd2;

  localparam logic [2:0] CFG_EPOCHS   = 3'd0;
  localparam logic [2:0] CFG_STEP     = 3'd1;
  localparam logic [2:0] CFG_STRENGTH = 3'd2;
  localparam logic [2:0] CFG_MODE     = 3'd3;
  localparam logic [2:0] CFG_ROWS     = 3'd4;
  localparam logic [2:0] CFG_FEATURES = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE, S_EP_START, S_ROW_START, S_PRED_RD, S_PRED_MUL, S_PRED_ACC, S_ERR,
    S_GR_RD, S_GR_MUL, S_GR_ACC, S_BIAS_ACC, S_UPD_DIV, S_UPD_WAIT, S_UPD_RMUL,
    S_UPD_REG, S_UPD_LO, S_UPD_HI, S_UPD_WR, S_LOSS_START, S_LOSS_MUL,
    S_LOSS_ACC, S_LDIV, S_LDIV_WAIT, S_LS_MUL, S_LS_ACC, S_LR_LO, S_LR_HI,
    S_LR_FIN, S_EMIT_W, S_EMIT_B, S_EMIT_L
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [47:0] sat48(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    c = (v > MAX48) ? MAX48 : ((v < MIN48) ? MIN48 : v);
    return c[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    c = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/lrgd_div.sv
// ----------------------------------------------------------------------------
// lrgd_div
// Bit-serial signed divider by the row count, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgd_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lrgd_pkg::div_ctl_t     ctl,
  input  wire signed [47:0]      dividend,
  input  wire        [8:0]       divisor,
  output lrgd_pkg::div_sts_t     sts,
  output logic signed [47:0]     quotient
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  shifted;
  logic [10:0] trial;

  assign shifted = {rem_r, quo_r[47]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      cnt_nxt  = 6'd48;
      rem_nxt  = '0;
      quo_nxt  = dividend[47] ? 48'(-dividend) : dividend;
      neg_nxt  = dividend[47];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[10]) begin
        rem_nxt = trial[8:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = shifted[8:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

FILE: src/linear_regression_gd_trainer.sv
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// Full-batch gradient descent trainer for linear regression in Q16.16.
// ----------------------------------------------------------------------------
// Input beats with func feature, target or parameter write the sample store,
// the target store, a weight or the bias; while idle they are taken one per cycle and give
// no result. A train beat runs epoch_count epochs and then sends the weights in
// use, the bias and the loss as result beats, the loss beat with last set.
// All multiplications and divisions go through one registered 33 by 33 bit
// multiplier and one bit-serial divider. With R rows and F features in use,
// an epoch passes over the R rows and then updates each weight and the bias,
// each update waiting on the divider; the loss pass waits on it once more and
// adds a regularizer term only when one is set. The F+2 result beats then
// leave one per cycle while the receiver does not stall.
// The input is stalled for the whole run.
// Results are held in an output register; a stalled result beat holds until
// taken, and the next result waits behind it. Synchronous reset clears the
// weights, the bias, the control state and loads the register defaults; the
// sample and target stores are not cleared and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_regression_gd_trainer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire        [1:0]  in_func,
  input  wire        [7:0]  in_row,
  input  wire        [3:0]  in_col,
  input  wire signed [31:0] in_value,
  output logic              out_valid,
  input  wire               out_stall,
  output logic       [1:0]  out_kind,
  output logic       [3:0]  out_index,
  output logic signed [47:0] out_result_value,
  output logic              out_last,
  input  wire               cfg_we,
  input  wire        [2:0]  cfg_index,
  input  wire        [15:0] cfg_wdata
);

  localparam int WW = lrgd_pkg::WW;
  localparam int FW = lrgd_pkg::FW;
  localparam int RW = lrgd_pkg::RW;

  lrgd_pkg::state_t state_r, state_nxt;

  logic [15:0] epochs_r, step_r, strength_r;
  logic [1:0]  mode_r;
  logic [8:0]  rows_r;
  logic [3:0]  feats_r;

  logic [8:0]  r_eff_r, r_eff_nxt;
  logic [3:0]  f_eff_r, f_eff_nxt;
  logic [RW-1:0] i_r, i_nxt;
  logic [FW-1:0] j_r, j_nxt;
  logic [15:0] ep_r, ep_nxt;
  logic        ub_r, ub_nxt;
  logic        lp_r, lp_nxt;

  logic signed [31:0] w_r [lrgd_pkg::FEATURES];
  logic signed [31:0] w_nxt [lrgd_pkg::FEATURES];
  logic signed [47:0] gs_r [lrgd_pkg::FEATURES];
  logic signed [47:0] gs_nxt [lrgd_pkg::FEATURES];
  logic signed [31:0] bias_r, bias_nxt;
  logic signed [47:0] bgs_r, bgs_nxt;
  logic signed [63:0] pred_r, pred_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [47:0] q_r, q_nxt;
  logic signed [47:0] g_r, g_nxt;
  logic signed [47:0] lsum_r, lsum_nxt;
  logic [51:0] s_r, s_nxt;
  logic signed [65:0] prod_r, acc_r, acc_nxt;
  logic signed [32:0] mul_a, mul_b;

  logic signed [31:0] smp_mem [lrgd_pkg::ROWS*lrgd_pkg::FEATURES];
  logic signed [31:0] tgt_mem [lrgd_pkg::ROWS];
  logic signed [31:0] smp_rd_r, tgt_rd_r;
  logic               in_acc, smp_we, tgt_we;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [3:0]         out_index_r, out_index_nxt;
  logic signed [47:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               can_load;

  lrgd_pkg::div_ctl_t div_ctl;
  lrgd_pkg::div_sts_t div_sts;
  logic signed [47:0] div_n, div_q;

  logic signed [WW-1:0] prod_w, acc_w, split_w, w_cur, tmp;
  logic signed [31:0]   w_sel;
  logic                 j_last, i_last, l1, l2;
  logic [47:0]          s_sat;

  assign in_stall = (state_r != lrgd_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_we   = in_acc && (in_func == lrgd_pkg::FUNC_FEAT) &&
                    (in_col < 4'(lrgd_pkg::FEATURES));
  assign tgt_we   = in_acc && (in_func == lrgd_pkg::FUNC_TARGET);

  assign l1      = (mode_r == lrgd_pkg::MODE_L1);
  assign l2      = (mode_r == lrgd_pkg::MODE_L2);
  assign j_last  = ({1'b0, j_r} == (f_eff_r - 4'd1));
  assign i_last  = ({1'b0, i_r} == (r_eff_r - 9'd1));
  assign w_sel   = w_r[j_r];
  assign prod_w  = WW'(prod_r);
  assign acc_w   = WW'(acc_r);
  assign split_w = (prod_w <<< 24) + acc_w;
  assign w_cur   = ub_r ? WW'(bias_r) : WW'(w_sel);
  assign s_sat   = (s_r > 52'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : s_r[47:0];
  assign can_load = !out_valid_r || !out_stall;

  // Stores
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[{in_row, in_col[FW-1:0]}] <= in_value;
    end
    if (tgt_we) begin
      tgt_mem[in_row] <= in_value;
    end
    smp_rd_r <= smp_mem[{i_r, j_r}];
    tgt_rd_r <= tgt_mem[i_r];
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epochs_r   <= 16'd100;
      step_r     <= 16'd655;
      strength_r <= 16'd0;
      mode_r     <= lrgd_pkg::MODE_NONE;
      rows_r     <= 9'(lrgd_pkg::ROWS);
      feats_r    <= 4'(lrgd_pkg::FEATURES);
    end else if (cfg_we) begin
      case (cfg_index)
        lrgd_pkg::CFG_EPOCHS:   epochs_r   <= cfg_wdata;
        lrgd_pkg::CFG_STEP:     step_r     <= cfg_wdata;
        lrgd_pkg::CFG_STRENGTH: strength_r <= cfg_wdata;
        lrgd_pkg::CFG_MODE:     mode_r     <= cfg_wdata[1:0];
        lrgd_pkg::CFG_ROWS:     rows_r     <= cfg_wdata[8:0];
        lrgd_pkg::CFG_FEATURES: feats_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      lrgd_pkg::S_PRED_MUL: begin mul_a = 33'(w_sel); mul_b = 33'(smp_rd_r); end
      lrgd_pkg::S_GR_MUL:   begin mul_a = 33'(err_r); mul_b = 33'(smp_rd_r); end
      lrgd_pkg::S_LOSS_MUL: begin mul_a = 33'(err_r); mul_b = 33'(err_r); end
      lrgd_pkg::S_LS_MUL:   begin mul_a = 33'(w_sel); mul_b = 33'(w_sel); end
      lrgd_pkg::S_UPD_RMUL: begin mul_a = {17'd0, strength_r}; mul_b = 33'(w_sel); end
      lrgd_pkg::S_UPD_LO: begin
        mul_a = {17'd0, step_r};
        mul_b = {9'd0, g_r[23:0]};
      end
      lrgd_pkg::S_UPD_HI: begin
        mul_a = {17'd0, step_r};
        mul_b = 33'($signed(g_r[47:24]));
      end
      lrgd_pkg::S_LR_LO: begin
        mul_a = {17'd0, strength_r};
        mul_b = {9'd0, s_sat[23:0]};
      end
      lrgd_pkg::S_LR_HI: begin
        mul_a = {17'd0, strength_r};
        mul_b = {9'd0, s_sat[47:24]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

  assign div_ctl.start = (state_r == lrgd_pkg::S_UPD_DIV) || (state_r == lrgd_pkg::S_LDIV);
  assign div_n = (state_r == lrgd_pkg::S_LDIV) ? lsum_r : (ub_r ? bgs_r : gs_r[j_r]);

  lrgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_n),
    .divisor  (r_eff_r),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrgd_pkg::S_IDLE: begin
        if (in_acc && in_func == lrgd_pkg::FUNC_TRAIN) begin
          state_nxt = (epochs_r == 16'd0) ? lrgd_pkg::S_LOSS_START : lrgd_pkg::S_EP_START;
        end
      end
      lrgd_pkg::S_EP_START:  state_nxt = lrgd_pkg::S_ROW_START;
      lrgd_pkg::S_ROW_START: state_nxt = lrgd_pkg::S_PRED_RD;
      lrgd_pkg::S_PRED_RD:   state_nxt = lrgd_pkg::S_PRED_MUL;
      lrgd_pkg::S_PRED_MUL:  state_nxt = lrgd_pkg::S_PRED_ACC;
      lrgd_pkg::S_PRED_ACC:  state_nxt = j_last ? lrgd_pkg::S_ERR : lrgd_pkg::S_PRED_RD;
      lrgd_pkg::S_ERR:       state_nxt = lp_r ? lrgd_pkg::S_LOSS_MUL : lrgd_pkg::S_GR_RD;
      lrgd_pkg::S_GR_RD:     state_nxt = lrgd_pkg::S_GR_MUL;
      lrgd_pkg::S_GR_MUL:    state_nxt = lrgd_pkg::S_GR_ACC;
      lrgd_pkg::S_GR_ACC:    state_nxt = j_last ? lrgd_pkg::S_BIAS_ACC : lrgd_pkg::S_GR_RD;
      lrgd_pkg::S_BIAS_ACC:  state_nxt = i_last ? lrgd_pkg::S_UPD_DIV : lrgd_pkg::S_ROW_START;
      lrgd_pkg::S_UPD_DIV:   state_nxt = lrgd_pkg::S_UPD_WAIT;
      lrgd_pkg::S_UPD_WAIT: begin
        if (div_sts.done) begin
          state_nxt = (!ub_r && l2) ? lrgd_pkg::S_UPD_RMUL : lrgd_pkg::S_UPD_REG;
        end
      end
      lrgd_pkg::S_UPD_RMUL: state_nxt = lrgd_pkg::S_UPD_REG;
      lrgd_pkg::S_UPD_REG:  state_nxt = lrgd_pkg::S_UPD_LO;
      lrgd_pkg::S_UPD_LO:   state_nxt = lrgd_pkg::S_UPD_HI;
      lrgd_pkg::S_UPD_HI:   state_nxt = lrgd_pkg::S_UPD_WR;
      lrgd_pkg::S_UPD_WR: begin
        if (!ub_r) begin
          state_nxt = lrgd_pkg::S_UPD_DIV;
        end else if ((ep_r + 16'd1) == epochs_r) begin
          state_nxt = lrgd_pkg::S_LOSS_START;
        end else begin
          state_nxt = lrgd_pkg::S_EP_START;
        end
      end
      lrgd_pkg::S_LOSS_START: state_nxt = lrgd_pkg::S_ROW_START;
      lrgd_pkg::S_LOSS_MUL:   state_nxt = lrgd_pkg::S_LOSS_ACC;
      lrgd_pkg::S_LOSS_ACC:   state_nxt = i_last ? lrgd_pkg::S_LDIV : lrgd_pkg::S_ROW_START;
      lrgd_pkg::S_LDIV:       state_nxt = lrgd_pkg::S_LDIV_WAIT;
      lrgd_pkg::S_LDIV_WAIT: begin
        if (div_sts.done) begin
          state_nxt = (l1 || l2) ? lrgd_pkg::S_LS_MUL : lrgd_pkg::S_LR_FIN;
        end
      end
      lrgd_pkg::S_LS_MUL: state_nxt = lrgd_pkg::S_LS_ACC;
      lrgd_pkg::S_LS_ACC: state_nxt = j_last ? lrgd_pkg::S_LR_LO : lrgd_pkg::S_LS_MUL;
      lrgd_pkg::S_LR_LO:  state_nxt = lrgd_pkg::S_LR_HI;
      lrgd_pkg::S_LR_HI:  state_nxt = lrgd_pkg::S_LR_FIN;
      lrgd_pkg::S_LR_FIN: state_nxt = lrgd_pkg::S_EMIT_W;
      lrgd_pkg::S_EMIT_W: begin
        if (can_load && j_last) begin
          state_nxt = lrgd_pkg::S_EMIT_B;
        end
      end
      lrgd_pkg::S_EMIT_B: begin
        if (can_load) begin
          state_nxt = lrgd_pkg::S_EMIT_L;
        end
      end
      lrgd_pkg::S_EMIT_L: begin
        if (can_load) begin
          state_nxt = lrgd_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrgd_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    r_eff_nxt = r_eff_r;
    f_eff_nxt = f_eff_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ep_nxt    = ep_r;
    ub_nxt    = ub_r;
    lp_nxt    = lp_r;
    w_nxt     = w_r;
    gs_nxt    = gs_r;
    bias_nxt  = bias_r;
    bgs_nxt   = bgs_r;
    pred_nxt  = pred_r;
    err_nxt   = err_r;
    q_nxt     = q_r;
    g_nxt     = g_r;
    lsum_nxt  = lsum_r;
    s_nxt     = s_r;
    acc_nxt   = acc_r;
    tmp       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      lrgd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            lrgd_pkg::FUNC_PARAM: begin
              if (in_col < 4'(lrgd_pkg::FEATURES)) begin
                w_nxt[in_col[FW-1:0]] = in_value;
              end else if (in_col == 4'(lrgd_pkg::FEATURES)) begin
                bias_nxt = in_value;
              end
            end
            lrgd_pkg::FUNC_TRAIN: begin
              r_eff_nxt = (rows_r == 9'd0) ? 9'd1 :
                          ((rows_r > 9'(lrgd_pkg::ROWS)) ? 9'(lrgd_pkg::ROWS) : rows_r);
              f_eff_nxt = (feats_r == 4'd0) ? 4'd1 :
                          ((feats_r > 4'(lrgd_pkg::FEATURES)) ? 4'(lrgd_pkg::FEATURES) :
                           feats_r);
              ep_nxt = '0;
              ub_nxt = 1'b0;
              lp_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      lrgd_pkg::S_EP_START: begin
        for (int k = 0; k < lrgd_pkg::FEATURES; k++) begin
          gs_nxt[k] = '0;
        end
        bgs_nxt = '0;
        i_nxt   = '0;
      end
      lrgd_pkg::S_ROW_START: begin
        j_nxt    = '0;
        pred_nxt = 64'(bias_r);
      end
      lrgd_pkg::S_PRED_ACC: begin
        tmp      = WW'(pred_r) + (prod_w >>> 16);
        pred_nxt = tmp[63:0];
        if (!j_last) begin
          j_nxt = j_r + FW'(1);
        end
      end
      lrgd_pkg::S_ERR: begin
        err_nxt = lrgd_pkg::sat32(WW'(tgt_rd_r) - WW'(pred_r));
        j_nxt   = '0;
      end
      lrgd_pkg::S_GR_ACC: begin
        gs_nxt[j_r] = lrgd_pkg::sat48(WW'(gs_r[j_r]) - (prod_w >>> 15));
        if (!j_last) begin
          j_nxt = j_r + FW'(1);
        end
      end
      lrgd_pkg::S_BIAS_ACC: begin
        bgs_nxt = lrgd_pkg::sat48(WW'(bgs_r) - (WW'(err_r) <<< 1));
        if (i_last) begin
          j_nxt = '0;
        end else begin
          i_nxt = i_r + RW'(1);
        end
      end
      lrgd_pkg::S_UPD_WAIT: begin
        if (div_sts.done) begin
          q_nxt = div_q;
        end
      end
      lrgd_pkg::S_UPD_REG: begin
        tmp = '0;
        if (!ub_r && l1) begin
          if (w_sel > 32'sd0) begin
            tmp = WW'({1'b0, strength_r});
          end else if (w_sel < 32'sd0) begin
            tmp = -WW'({1'b0, strength_r});
          end
        end else if (!ub_r && l2) begin
          tmp = prod_w >>> 15;
        end
        g_nxt = lrgd_pkg::sat48(WW'(q_r) + tmp);
      end
      lrgd_pkg::S_UPD_HI: begin
        acc_nxt = prod_r;
      end
      lrgd_pkg::S_UPD_WR: begin
        if (ub_r) begin
          bias_nxt = lrgd_pkg::sat32(w_cur - (split_w >>> 16));
          ub_nxt   = 1'b0;
          ep_nxt   = ep_r + 16'd1;
        end else begin
          w_nxt[j_r] = lrgd_pkg::sat32(w_cur - (split_w >>> 16));
          if (j_last) begin
            ub_nxt = 1'b1;
          end else begin
            j_nxt = j_r + FW'(1);
          end
        end
      end
      lrgd_pkg::S_LOSS_START: begin
        lp_nxt   = 1'b1;
        lsum_nxt = '0;
        i_nxt    = '0;
      end
      lrgd_pkg::S_LOSS_ACC: begin
        lsum_nxt = lrgd_pkg::sat48(WW'(lsum_r) + (prod_w >>> 16));
        if (!i_last) begin
          i_nxt = i_r + RW'(1);
        end
      end
      lrgd_pkg::S_LDIV_WAIT: begin
        if (div_sts.done) begin
          q_nxt = div_q;
          s_nxt = '0;
          j_nxt = '0;
        end
      end
      lrgd_pkg::S_LS_ACC: begin
        if (l1) begin
          s_nxt = s_r + ((w_sel < 32'sd0) ? 52'(-WW'(w_sel)) : 52'(WW'(w_sel)));
        end else begin
          tmp   = prod_w >>> 16;
          s_nxt = s_r + tmp[51:0];
        end
        if (!j_last) begin
          j_nxt = j_r + FW'(1);
        end
      end
      lrgd_pkg::S_LR_HI: begin
        acc_nxt = prod_r;
      end
      lrgd_pkg::S_LR_FIN: begin
        tmp      = (l1 || l2) ? (split_w >>> 16) : '0;
        lsum_nxt = lrgd_pkg::sat48(WW'(q_r) + tmp);
        j_nxt    = '0;
      end
      lrgd_pkg::S_EMIT_W: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lrgd_pkg::KIND_WEIGHT;
          out_index_nxt = {1'b0, j_r};
          out_value_nxt = 48'(w_sel);
          out_last_nxt  = 1'b0;
          if (!j_last) begin
            j_nxt = j_r + FW'(1);
          end
        end
      end
      lrgd_pkg::S_EMIT_B: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lrgd_pkg::KIND_BIAS;
          out_index_nxt = '0;
          out_value_nxt = 48'(bias_r);
          out_last_nxt  = 1'b0;
        end
      end
      lrgd_pkg::S_EMIT_L: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lrgd_pkg::KIND_LOSS;
          out_index_nxt = '0;
          out_value_nxt = lsum_r;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrgd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      bias_r      <= '0;
      bgs_r       <= '0;
      ep_r        <= '0;
      ub_r        <= 1'b0;
      lp_r        <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      r_eff_r     <= 9'(lrgd_pkg::ROWS);
      f_eff_r     <= 4'(lrgd_pkg::FEATURES);
      for (int k = 0; k < lrgd_pkg::FEATURES; k++) begin
        w_r[k]  <= '0;
        gs_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bias_r      <= bias_nxt;
      bgs_r       <= bgs_nxt;
      ep_r        <= ep_nxt;
      ub_r        <= ub_nxt;
      lp_r        <= lp_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      r_eff_r     <= r_eff_nxt;
      f_eff_r     <= f_eff_nxt;
      w_r         <= w_nxt;
      gs_r        <= gs_nxt;
    end
    pred_r      <= pred_nxt;
    err_r       <= err_nxt;
    q_r         <= q_nxt;
    g_r         <= g_nxt;
    lsum_r      <= lsum_nxt;
    s_r         <= s_nxt;
    out_kind_r  <= out_kind_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_index        = out_index_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

  a_last_is_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == lrgd_pkg::KIND_LOSS))
    else $error("last beat is not the loss");

  a_train_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == lrgd_pkg::FUNC_TRAIN) |=> in_stall)
    else $error("train beat did not start a run");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == lrgd_pkg::S_UPD_WAIT || state_r == lrgd_pkg::S_LDIV_WAIT))
    else $error("divider finished outside a wait state");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrgd_pkg::S_EMIT_W) |-> ({1'b0, j_r} < f_eff_r))
    else $error("weight beat index out of range");

endmodule

`default_nettype wire

FILE: verif/tb_linear_regression_gd_trainer.sv
// ----------------------------------------------------------------------------
// tb_linear_regression_gd_trainer
// Self-checking testbench for the gradient descent trainer.
// ----------------------------------------------------------------------------
// A queue of pending load and train beats feeds a clocked driver that sends in
// bursts. Accepted beats update a local fixed-point copy of the trainer, which
// predicts the weight, bias and loss beats of every train command. A clocked
// monitor compares each result beat with the oldest prediction while the
// output side stalls on a pattern of its own. Configuration changes only while
// the block is idle, and a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_regression_gd_trainer;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 400000;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -S48_MAX - 1;
  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = -S32_MAX - 1;

  typedef struct {
    logic [1:0]         func;
    logic [7:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } load_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  index;
    logic [47:0] value;
    logic        last;
  } fit_beat_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_func;
  logic [7:0] in_row;
  logic [3:0] in_col;
  logic signed [31:0] in_value;
  logic out_valid, out_stall;
  logic [1:0] out_kind;
  logic [3:0] out_index;
  logic signed [47:0] out_result_value;
  logic out_last;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  linear_regression_gd_trainer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_row(in_row),
    .in_col(in_col), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_index(out_index), .out_result_value(out_result_value), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  load_beat_t pending_beats[$];
  fit_beat_t  fit_expected[$];
  int errors = 0;
  int beats_queued = 0;

  logic signed [31:0] samples[lrgd_pkg::ROWS][lrgd_pkg::FEATURES];
  logic signed [31:0] targets[lrgd_pkg::ROWS];
  logic signed [31:0] weights[lrgd_pkg::FEATURES];
  logic signed [31:0] bias_q;
  bit sample_ok[lrgd_pkg::ROWS][lrgd_pkg::FEATURES];
  bit target_ok[lrgd_pkg::ROWS];
  int epochs_cfg, step_cfg, lambda_cfg, mode_cfg, rows_cfg, feats_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint row_error(int i, int f);
    longint pred;
    pred = longint'(bias_q);
    for (int j = 0; j < f; j++) begin
      pred += (longint'(weights[j]) * longint'(samples[i][j])) >>> 16;
    end
    return clamp(longint'(targets[i]) - pred, S32_MIN, S32_MAX);
  endfunction

  task automatic train_epoch(int r, int f);
    longint gsum[lrgd_pkg::FEATURES];
    longint bsum, e, w, g;
    bsum = 0;
    for (int j = 0; j < lrgd_pkg::FEATURES; j++) gsum[j] = 0;
    for (int i = 0; i < r; i++) begin
      e = row_error(i, f);
      for (int j = 0; j < f; j++) begin
        gsum[j] = clamp(gsum[j] - ((e * longint'(samples[i][j])) >>> 15), S48_MIN, S48_MAX);
      end
      bsum = clamp(bsum - 2 * e, S48_MIN, S48_MAX);
    end
    for (int j = 0; j < f; j++) begin
      w = longint'(weights[j]);
      g = gsum[j] / longint'(r);
      if (mode_cfg == lrgd_pkg::MODE_L1) begin
        g += (w > 0) ? longint'(lambda_cfg) : ((w < 0) ? -longint'(lambda_cfg) : 0);
      end else if (mode_cfg == lrgd_pkg::MODE_L2) begin
        g += (longint'(lambda_cfg) * w) >>> 15;
      end
      g = clamp(g, S48_MIN, S48_MAX);
      weights[j] = 32'(clamp(w - ((longint'(step_cfg) * g) >>> 16), S32_MIN, S32_MAX));
    end
    g = bsum / longint'(r);
    bias_q = 32'(clamp(longint'(bias_q) - ((longint'(step_cfg) * g) >>> 16),
                       S32_MIN, S32_MAX));
  endtask

  function automatic int rows_eff();
    return rows_cfg == 0 ? 1 : (rows_cfg > lrgd_pkg::ROWS ? lrgd_pkg::ROWS : rows_cfg);
  endfunction

  function automatic int feats_eff();
    return feats_cfg == 0 ? 1 :
           (feats_cfg > lrgd_pkg::FEATURES ? lrgd_pkg::FEATURES : feats_cfg);
  endfunction

  task automatic predict_fit();
    int r, f;
    longint sum, pen, w, e;
    fit_beat_t b;
    r = rows_eff();
    f = feats_eff();
    for (int k = 0; k < epochs_cfg; k++) train_epoch(r, f);
    for (int j = 0; j < f; j++) begin
      b.kind = lrgd_pkg::KIND_WEIGHT; b.index = 4'(j); b.last = 1'b0;
      b.value = 48'(longint'(weights[j]));
      fit_expected.push_back(b);
    end
    b.kind = lrgd_pkg::KIND_BIAS; b.index = 4'd0; b.last = 1'b0;
    b.value = 48'(longint'(bias_q));
    fit_expected.push_back(b);
    sum = 0;
    pen = 0;
    for (int i = 0; i < r; i++) begin
      e = row_error(i, f);
      sum = clamp(sum + ((e * e) >>> 16), S48_MIN, S48_MAX);
    end
    sum = sum / longint'(r);
    if (mode_cfg == lrgd_pkg::MODE_L1 || mode_cfg == lrgd_pkg::MODE_L2) begin
      for (int j = 0; j < f; j++) begin
        w = longint'(weights[j]);
        pen += (mode_cfg == lrgd_pkg::MODE_L1) ? (w < 0 ? -w : w) : ((w * w) >>> 16);
      end
      pen = clamp(pen, S48_MIN, S48_MAX);
      pen = (longint'(lambda_cfg) * pen) >>> 16;
    end
    b.kind = lrgd_pkg::KIND_LOSS; b.index = 4'd0; b.last = 1'b1;
    b.value = 48'(clamp(sum + pen, S48_MIN, S48_MAX));
    fit_expected.push_back(b);
  endtask

  task automatic apply_beat(load_beat_t t);
    case (t.func)
      lrgd_pkg::FUNC_FEAT: if (t.col < lrgd_pkg::FEATURES) samples[t.row][t.col] = t.value;
      lrgd_pkg::FUNC_TARGET: targets[t.row] = t.value;
      lrgd_pkg::FUNC_PARAM: begin
        if (t.col < lrgd_pkg::FEATURES) weights[t.col] = t.value;
        else if (t.col == lrgd_pkg::FEATURES) bias_q = t.value;
      end
      default: predict_fit();
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
      default: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
    endcase
  endfunction

  task automatic queue_beat(logic [1:0] func, logic [7:0] row, logic [3:0] col,
                            logic signed [31:0] value);
    load_beat_t t;
    t.func = func; t.row = row; t.col = col; t.value = value;
    if (func == lrgd_pkg::FUNC_FEAT && col < lrgd_pkg::FEATURES) sample_ok[row][col] = 1'b1;
    if (func == lrgd_pkg::FUNC_TARGET) target_ok[row] = 1'b1;
    pending_beats.push_back(t);
    beats_queued++;
  endtask

  task automatic fill_training_set();
    for (int i = 0; i < rows_eff(); i++) begin
      for (int j = 0; j < feats_eff(); j++) begin
        if (!sample_ok[i][j]) queue_beat(lrgd_pkg::FUNC_FEAT, 8'(i), 4'(j), pick_value());
      end
      if (!target_ok[i]) queue_beat(lrgd_pkg::FUNC_TARGET, 8'(i), 4'd0, pick_value());
    end
  endtask

  task automatic queue_fit();
    fill_training_set();
    queue_beat(lrgd_pkg::FUNC_TRAIN, 8'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic write_reg(logic [2:0] idx, int data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = 16'(data);
    case (idx)
      lrgd_pkg::CFG_EPOCHS:   epochs_cfg = data & 16'hFFFF;
      lrgd_pkg::CFG_STEP:     step_cfg = data & 16'hFFFF;
      lrgd_pkg::CFG_STRENGTH: lambda_cfg = data & 16'hFFFF;
      lrgd_pkg::CFG_MODE:     mode_cfg = data & 3;
      lrgd_pkg::CFG_ROWS:     rows_cfg = data & 9'h1FF;
      lrgd_pkg::CFG_FEATURES: feats_cfg = data & 4'hF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(int ep, int st, int lam, int md, int rw, int ft);
    write_reg(lrgd_pkg::CFG_EPOCHS, ep);
    write_reg(lrgd_pkg::CFG_STEP, st);
    write_reg(lrgd_pkg::CFG_STRENGTH, lam);
    write_reg(lrgd_pkg::CFG_MODE, md);
    write_reg(lrgd_pkg::CFG_ROWS, rw);
    write_reg(lrgd_pkg::CFG_FEATURES, ft);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || fit_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  // Driver: bursts of beats with random gaps, changed on the falling edge.
  bit in_fire;
  int burst_left = 0, gap_left = 0, stall_left = 0;
  bit stall_on = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid = 1'b0;
        end else if (pending_beats.size() != 0) begin
          load_beat_t t;
          t = pending_beats.pop_front();
          in_func = t.func; in_row = t.row; in_col = t.col; in_value = t.value;
          in_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid = 1'b0;
        end
      end
      if (stall_left == 0) begin
        stall_left = $urandom_range(30, 300);
        stall_on = ~stall_on;
      end else begin
        stall_left--;
      end
      out_stall = stall_on ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  // Monitor and model update on the rising edge.
  int idle_cycles = 0;

  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      load_beat_t t;
      t.func = in_func; t.row = in_row; t.col = in_col; t.value = in_value;
      apply_beat(t);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (fit_expected.size() == 0) begin
        $display("%0t: result beat with none expected: kind %0d index %0d value %0d",
                 $time, out_kind, out_index, out_result_value);
        errors++;
      end else begin
        fit_beat_t b;
        b = fit_expected.pop_front();
        if (out_kind !== b.kind)
          begin $display("%0t: kind expected %0d actual %0d", $time, b.kind, out_kind);
          errors++; end
        if (out_index !== b.index)
          begin $display("%0t: index expected %0d actual %0d", $time, b.index, out_index);
          errors++; end
        if (out_result_value !== b.value)
          begin $display("%0t: value expected %0d actual %0d", $time, $signed(b.value),
                         out_result_value);
          errors++; end
        if (out_last !== b.last)
          begin $display("%0t: last expected %0d actual %0d", $time, b.last, out_last);
          errors++; end
      end
    end
    if (in_fire || (out_valid && !out_stall) ||
        (pending_beats.size() == 0 && !in_valid && fit_expected.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_linear_regression_gd_trainer: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    in_valid = 1'b0; in_func = lrgd_pkg::FUNC_FEAT; in_row = '0; in_col = '0;
    in_value = '0;
    out_stall = 1'b0; cfg_we = 1'b0; cfg_index = lrgd_pkg::CFG_EPOCHS; cfg_wdata = '0;
    in_fire = 1'b0;
    rst_n = 1'b0;
    bias_q = '0;
    for (int j = 0; j < lrgd_pkg::FEATURES; j++) weights[j] = '0;
    for (int i = 0; i < lrgd_pkg::ROWS; i++) begin
      targets[i] = '0;
      target_ok[i] = 1'b0;
      for (int j = 0; j < lrgd_pkg::FEATURES; j++) begin
        samples[i][j] = '0;
        sample_ok[i][j] = 1'b0;
      end
    end
    epochs_cfg = 100; step_cfg = 655; lambda_cfg = 0; mode_cfg = lrgd_pkg::MODE_NONE;
    rows_cfg = 256; feats_cfg = 8;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_all(0, 65535, 65535, MODE_SPARE, 0, 0);
    queue_beat(lrgd_pkg::FUNC_FEAT, 8'd0, 4'd0, 32'sh7FFFFFFF);
    queue_beat(lrgd_pkg::FUNC_TARGET, 8'd0, 4'd0, 32'sh80000000);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd0, 4'd0, 32'sh80000000);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd0, 4'd8, 32'sh7FFFFFFF);
    queue_beat(lrgd_pkg::FUNC_FEAT, 8'd255, 4'd15, 32'sh12345678);
    queue_beat(lrgd_pkg::FUNC_FEAT, 8'd255, 4'd8, 32'sh0);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd255, 4'd15, 32'sh7FFFFFFF);
    queue_fit();
    drain();
    write_all(3, 32768, 1000, lrgd_pkg::MODE_L1, 2, 2);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd0, 4'd1, 32'sh10000);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd0, 4'd0, 32'sh0);
    queue_beat(lrgd_pkg::FUNC_PARAM, 8'd0, 4'd8, -32'sh8000);
    queue_fit();
    drain();
    write_all(2, 4000, 65535, lrgd_pkg::MODE_L2, 1, 15);
    queue_fit();
    drain();

    phase = 0;
    while (beats_queued < 360) begin
      phase++;
      if (phase == 6) begin
        write_all(1, $urandom_range(0, 2000), $urandom_range(0, 65535),
                  $urandom_range(0, 3), 0, 0);
      end else if (phase == 12) begin
        write_all(1, 655, 0, lrgd_pkg::MODE_NONE, 12, 1);
      end else if ($urandom_range(0, 1) == 0) begin
        write_all(($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3),
                  ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 8000),
                  ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 4000),
                  $urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 15));
      end
      repeat ($urandom_range(0, 4)) begin
        queue_beat(2'($urandom_range(0, 2)), 8'($urandom), 4'($urandom), pick_value());
      end
      repeat ($urandom_range(0, 3)) begin
        queue_beat(lrgd_pkg::FUNC_PARAM, 8'($urandom), 4'($urandom_range(0, 8)),
                   pick_value());
      end
      queue_fit();
      if ($urandom_range(0, 3) == 0) queue_fit();
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_linear_regression_gd_trainer: done, clean");
    end else begin
      $display("tb_linear_regression_gd_trainer: done, errors");
    end
    $finish;
  end

endmodule
